@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_CLK_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_CLK_NORST(lbl, clk, prop)
`endif

`endif

@@ design/hcp_pkg.sv @@
// ----------------------------------------------------------------------------
// HOG cell histogram packer package
// Widths, types and constants shared by the packer modules and interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package hcp_pkg;

  localparam int PIX_W    = 8;
  localparam int BIN_W    = 4;
  localparam int NUM_BINS = 8;
  localparam int CODE_W   = $clog2(NUM_BINS);
  localparam int MAG_W    = PIX_W + 1;
  localparam int HIST_W   = BIN_W * NUM_BINS;

  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [BIN_W-1:0]  bin_t;
  typedef logic [HIST_W-1:0] hist_t;

  typedef struct packed {
    pix_t cur_pixel;
    pix_t left_pixel;
    pix_t up_pixel;
    logic cell_end;
  } pix_item_t;

  typedef struct packed {
    code_t code;
    logic  count;
  } hcp_vote_t;

  typedef struct packed {
    hist_t hist_word;
    logic  bin_overflow;
  } hist_item_t;

endpackage

`default_nettype wire

@@ design/hcp_if.sv @@
// ----------------------------------------------------------------------------
// HOG cell histogram packer channel interfaces
// Valid/ready channels for pixel items and packed histogram results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcp_in_if import hcp_pkg::*; ();
  logic valid;
  logic ready;
  pix_t cur_pixel;
  pix_t left_pixel;
  pix_t up_pixel;
  logic cell_end;

  modport source (output valid, output cur_pixel, output left_pixel,
                  output up_pixel, output cell_end, input ready);
  modport sink   (input valid, input cur_pixel, input left_pixel,
                  input up_pixel, input cell_end, output ready);
endinterface

interface hcp_out_if import hcp_pkg::*; ();
  logic  valid;
  logic  ready;
  hist_t hist_word;
  logic  bin_overflow;

  modport source (output valid, output hist_word, output bin_overflow, input ready);
  modport sink   (input valid, input hist_word, input bin_overflow, output ready);
endinterface

`default_nettype wire

@@ design/hcp_grad.sv @@
// ----------------------------------------------------------------------------
// Gradient and orientation vote
// Forms the signed gradients, the orientation code and the threshold test.
// ----------------------------------------------------------------------------
`default_nettype none

module hcp_grad import hcp_pkg::*; (
  input  pix_t      cur_pixel,
  input  pix_t      left_pixel,
  input  pix_t      up_pixel,
  input  mag_t      mag_threshold,
  output hcp_vote_t vote
);

  logic [PIX_W:0] gx;
  logic [PIX_W:0] gy;
  logic [PIX_W:0] gx_neg;
  logic [PIX_W:0] gy_neg;
  pix_t           ax;
  pix_t           ay;
  mag_t           mag;

  always_comb begin
    gx     = {1'b0, cur_pixel} - {1'b0, left_pixel};
    gy     = {1'b0, up_pixel} - {1'b0, cur_pixel};
    gx_neg = -gx;
    gy_neg = -gy;
    ax     = gx[PIX_W] ? gx_neg[PIX_W-1:0] : gx[PIX_W-1:0];
    ay     = gy[PIX_W] ? gy_neg[PIX_W-1:0] : gy[PIX_W-1:0];
    mag    = {1'b0, ax} + {1'b0, ay};
    vote.code  = {gy[PIX_W], gx[PIX_W], (ay > ax)};
    vote.count = (mag >= mag_threshold);
  end

endmodule

`default_nettype wire

@@ design/hcp_bins.sv @@
// ----------------------------------------------------------------------------
// Saturating bin accumulator
// Holds the eight orientation bins of the current cell and packs them.
// ----------------------------------------------------------------------------
`default_nettype none

module hcp_bins import hcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd,
  input  logic       cell_end,
  input  hcp_vote_t  vote,
  output hist_item_t packed_nxt
);

  bin_t bins_r   [NUM_BINS];
  bin_t bins_nxt [NUM_BINS];
  logic ovf_r;
  logic ovf_nxt;
  logic sat_hit;

  always_comb begin
    sat_hit = vote.count && (bins_r[vote.code] == BIN_MAX);
    for (int i = 0; i < NUM_BINS; i++) begin
      if (vote.count && (vote.code == code_t'(i)) && (bins_r[i] != BIN_MAX)) begin
        bins_nxt[i] = bins_r[i] + bin_t'(1);
      end else begin
        bins_nxt[i] = bins_r[i];
      end
      packed_nxt.hist_word[i*BIN_W +: BIN_W] = bins_nxt[i];
    end
    ovf_nxt = ovf_r | sat_hit;
    packed_nxt.bin_overflow = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_r[i] <= '0;
      end
      ovf_r <= 1'b0;
    end else if (upd) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_r[i] <= cell_end ? '0 : bins_nxt[i];
      end
      ovf_r <= cell_end ? 1'b0 : ovf_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/hog_cell_histogram_packer_unit.sv @@
// A result is captured in the result register when the last pixel of its cell leaves the input register.
// Throughput: one pixel per cycle while no cell end is stalled; the bin update is a
// read-modify-write of the bin registers between the input and result registers.
// A cell end stalls only while the result register still holds an untaken result.
// Reset (synchronous, active low) clears the bins, the overflow mark, the threshold
// and both valid flags.
// ----------------------------------------------------------------------------
// HOG cell histogram packer
// Builds an 8-bin orientation histogram per cell and emits it packed in a word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hog_cell_histogram_packer_unit import hcp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  mag_t         cfg_wdata,
  hcp_in_if.sink       in_chan,
  hcp_out_if.source    out_chan
);

  mag_t       thr_r;
  pix_item_t  s1_r;
  logic       s1_valid_r;
  logic       s1_fire;
  logic       out_free;
  hist_item_t out_r;
  logic       out_valid_r;
  hcp_vote_t  vote;
  hist_item_t packed_nxt;
  logic       any_full;

  assign out_free     = !out_valid_r || out_chan.ready;
  assign s1_fire      = s1_valid_r && (!s1_r.cell_end || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_r.cur_pixel  <= in_chan.cur_pixel;
      s1_r.left_pixel <= in_chan.left_pixel;
      s1_r.up_pixel   <= in_chan.up_pixel;
      s1_r.cell_end   <= in_chan.cell_end;
    end
  end

  hcp_grad u_grad (
    .cur_pixel     (s1_r.cur_pixel),
    .left_pixel    (s1_r.left_pixel),
    .up_pixel      (s1_r.up_pixel),
    .mag_threshold (thr_r),
    .vote          (vote)
  );

  hcp_bins u_bins (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (s1_fire),
    .cell_end   (s1_r.cell_end),
    .vote       (vote),
    .packed_nxt (packed_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_r.cell_end) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_r.cell_end) begin
      out_r <= packed_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.hist_word    = out_r.hist_word;
  assign out_chan.bin_overflow = out_r.bin_overflow;

  always_comb begin
    any_full = 1'b0;
    for (int i = 0; i < NUM_BINS; i++) begin
      any_full = any_full | (out_r.hist_word[i*BIN_W +: BIN_W] == BIN_MAX);
    end
  end

  `ASSERT_CLK(a_no_overwrite, clk, rst_n,
              !(out_valid_r && !out_chan.ready && s1_fire && s1_r.cell_end))
  `ASSERT_CLK(a_out_from_end, clk, rst_n,
              $rose(out_valid_r) |-> $past(s1_fire && s1_r.cell_end))
  `ASSERT_CLK(a_ovf_has_full_bin, clk, rst_n,
              (out_valid_r && out_r.bin_overflow) |-> any_full)
  `ASSERT_CLK_NORST(a_empty_ready, clk, (rst_n && !s1_valid_r) |-> in_chan.ready)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// HOG cell histogram packer testbench
// Streams pixel transactions into the packer, predicts each packed 8-bin
// histogram with a cycle-free model of the binning and checks every result
// transaction. Walks through several threshold settings and traffic patterns,
// including a long result-side hold-off that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import hcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;
  localparam int SEG_ITEMS   = 235;
  localparam int NUM_SEGS    = 7;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  mag_t cfg_wdata;

  hcp_in_if  in_chan ();
  hcp_out_if out_chan ();

  hog_cell_histogram_packer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  always #6 clk = ~clk;

  pix_item_t  pending_pixels [$];
  hist_item_t expected_hists [$];

  bin_t cell_bins [NUM_BINS];
  logic cell_ovf;
  mag_t mag_thr;

  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  logic hold_armed   = 1'b0;
  logic hold_off     = 1'b0;

  int n_pixels    = 0;
  int n_hists     = 0;
  int n_ovf_hists = 0;
  int n_thr_sets  = 0;
  int n_errors    = 0;

  function automatic bit bin_pixel(input pix_item_t px, output hist_item_t res);
    int    gx;
    int    gy;
    int    ax;
    int    ay;
    int    i;
    code_t code;
    gx   = int'(px.cur_pixel) - int'(px.left_pixel);
    gy   = int'(px.up_pixel) - int'(px.cur_pixel);
    ax   = (gx < 0) ? -gx : gx;
    ay   = (gy < 0) ? -gy : gy;
    code = {gy < 0, gx < 0, ay > ax};
    if (ax + ay >= int'(mag_thr)) begin
      if (cell_bins[code] == BIN_MAX) begin
        cell_ovf = 1'b1;
      end else begin
        cell_bins[code] = cell_bins[code] + bin_t'(1);
      end
    end
    res = '0;
    if (!px.cell_end) begin
      return 1'b0;
    end
    for (i = 0; i < NUM_BINS; i++) begin
      res.hist_word[i*BIN_W +: BIN_W] = cell_bins[i];
      cell_bins[i] = '0;
    end
    res.bin_overflow = cell_ovf;
    cell_ovf = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    pix_item_t  px;
    hist_item_t res;
    int         i;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      for (i = 0; i < NUM_BINS; i++) begin
        cell_bins[i] = '0;
      end
      cell_ovf = 1'b0;
      mag_thr  = '0;
    end else begin
      if (cfg_we) begin
        mag_thr = cfg_wdata;
      end
      if (in_chan.valid && in_chan.ready) begin
        px = '{in_chan.cur_pixel, in_chan.left_pixel, in_chan.up_pixel, in_chan.cell_end};
        n_pixels++;
        if (bin_pixel(px, res)) begin
          expected_hists.push_back(res);
        end
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          px = pending_pixels.pop_front();
          in_chan.valid      <= 1'b1;
          in_chan.cur_pixel  <= px.cur_pixel;
          in_chan.left_pixel <= px.left_pixel;
          in_chan.up_pixel   <= px.up_pixel;
          in_chan.cell_end   <= px.cell_end;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    hist_item_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        n_hists++;
        if (out_chan.bin_overflow) begin
          n_ovf_hists++;
        end
        if (expected_hists.size() == 0) begin
          $display("%0t: unexpected result transaction, got hist_word %h bin_overflow %b",
                   $time, out_chan.hist_word, out_chan.bin_overflow);
          n_errors++;
        end else begin
          want = expected_hists.pop_front();
          if (out_chan.hist_word !== want.hist_word) begin
            $display("%0t: hist_word mismatch, expected %h, actual %h",
                     $time, want.hist_word, out_chan.hist_word);
            n_errors++;
          end
          if (out_chan.bin_overflow !== want.bin_overflow) begin
            $display("%0t: bin_overflow mismatch, expected %b, actual %b",
                     $time, want.bin_overflow, out_chan.bin_overflow);
            n_errors++;
          end
        end
      end
      out_chan.ready <= !hold_off && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    wait (hold_armed);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_px(input int c, input int l, input int u, input bit last);
    pix_item_t px;
    px.cur_pixel  = pix_t'(c);
    px.left_pixel = pix_t'(l);
    px.up_pixel   = pix_t'(u);
    px.cell_end   = last;
    pending_pixels.push_back(px);
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_pixels.size() != 0 || in_chan.valid || expected_hists.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(input mag_t thr);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_thr_sets++;
    @(negedge clk);
  endtask

  function automatic pix_t corner_pix();
    int sel;
    sel = $urandom_range(2);
    if (sel == 0) begin
      return 8'd0;
    end else if (sel == 1) begin
      return 8'd255;
    end
    return pix_t'($urandom);
  endfunction

  task automatic queue_random_cell(output int len);
    int   kind;
    int   j;
    pix_t c;
    pix_t l;
    pix_t u;
    pix_t fc;
    pix_t fl;
    pix_t fu;
    kind = $urandom_range(99);
    if (kind < 60) begin
      len = 16;
    end else if (kind < 75) begin
      len = $urandom_range(16, 24);
    end else if (kind < 90) begin
      len = $urandom_range(1, 40);
    end else begin
      len = $urandom_range(4, 16);
    end
    fc = pix_t'($urandom);
    fl = pix_t'($urandom);
    fu = pix_t'($urandom);
    for (j = 0; j < len; j++) begin
      if (kind >= 90) begin
        c = corner_pix();
        l = corner_pix();
        u = corner_pix();
      end else if (kind >= 60 && kind < 75 && $urandom_range(99) < 80) begin
        c = fc;
        l = fl;
        u = fu;
      end else begin
        c = pix_t'($urandom);
        l = pix_t'($urandom);
        u = pix_t'($urandom);
      end
      push_px(int'(c), int'(l), int'(u), j == len - 1);
    end
  endtask

  initial begin
    int seg;
    int seg_items;
    int len;
    int j;
    mag_t seg_thr;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.cur_pixel  = '0;
    in_chan.left_pixel = '0;
    in_chan.up_pixel   = '0;
    in_chan.cell_end   = 1'b0;
    out_chan.ready     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    snd_idle_pct = 16;
    rcv_idle_pct = 77;

    // Reset threshold of zero: one pixel per orientation, zero gradient and a tie.
    push_px(0, 0, 0, 1'b0);
    push_px(255, 0, 0, 1'b0);
    push_px(0, 255, 255, 1'b0);
    push_px(0, 0, 255, 1'b0);
    push_px(255, 255, 0, 1'b0);
    push_px(0, 255, 0, 1'b0);
    push_px(10, 20, 100, 1'b0);
    push_px(100, 200, 50, 1'b0);
    push_px(100, 120, 0, 1'b0);
    push_px(100, 0, 110, 1'b0);
    push_px(100, 50, 150, 1'b1);
    // Flat cell that saturates bin zero.
    for (j = 0; j < 16; j++) begin
      push_px(77, 77, 77, j == 15);
    end
    // Threshold above the largest magnitude on a single-pixel cell.
    set_threshold(9'd511);
    push_px(255, 0, 0, 1'b1);
    // Threshold at the largest magnitude.
    set_threshold(9'd510);
    push_px(0, 255, 255, 1'b0);
    push_px(255, 1, 0, 1'b1);

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0: seg_thr = 9'd0;
        1: seg_thr = mag_t'($urandom_range(1, 100));
        2: seg_thr = 9'd511;
        3: seg_thr = mag_t'($urandom_range(101, 300));
        4: seg_thr = 9'd510;
        5: seg_thr = mag_t'($urandom_range(0, 40));
        default: seg_thr = mag_t'($urandom_range(0, 510));
      endcase
      set_threshold(seg_thr);
      if (seg == 3) begin
        snd_idle_pct = 77;
        rcv_idle_pct = 16;
      end else if (seg == 5) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      seg_items = 0;
      while (seg_items < SEG_ITEMS) begin
        queue_random_cell(len);
        seg_items += len;
      end
      if (seg == 5) begin
        hold_armed = 1'b1;
      end
    end
    drain();

    $display("Summary: %0d pixel transactions, %0d histogram transactions checked",
             n_pixels, n_hists);
    $display("Summary: %0d histograms with overflow, %0d threshold settings",
             n_ovf_hists, n_thr_sets);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
